### hdl/hsc_pkg.sv
// Shared constants and types of the heightmap slope classifier.
// No dependencies; every other file imports this package.
package hsc_pkg;

    localparam int MAX_COLS    = 128;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = 16;
    localparam int HGT_W       = 16;
    localparam int GCOLS_W     = 8;
    localparam int THR_W       = 16;
    localparam int DIFF_W      = HGT_W + 1;
    localparam int MAG_W       = 16;
    localparam int CLS_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEEP_THR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODERATE_THR = 2'd3;

    localparam logic [ROW_W-1:0]   RST_GRID_ROWS    = 16'd100;
    localparam logic [GCOLS_W-1:0] RST_GRID_COLS    = 8'd100;
    localparam logic [THR_W-1:0]   RST_STEEP_THR    = 16'd204;
    localparam logic [THR_W-1:0]   RST_MODERATE_THR = 16'd128;

    localparam logic [CLS_W-1:0] CLS_FLAT     = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MODERATE = 2'd1;
    localparam logic [CLS_W-1:0] CLS_STEEP    = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dz;
        logic              interior;
        logic              end_grid;
        logic              last;
    } slope_job_t;

endpackage

### hdl/hsc_front.sv
// Front end: accepts height words, keeps the two line buffers and emits slope jobs.
// Depends on hsc_pkg.
module hsc_front import hsc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [HGT_W-1:0]   s_height,
    input  logic [ROW_W-1:0]   grid_rows,
    input  logic [GCOLS_W-1:0] grid_cols,
    output logic               q_push,
    output slope_job_t         q_data,
    input  logic               q_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_READ = 3'd1;
    localparam logic [2:0] F_CALC = 3'd2;
    localparam logic [2:0] F_WR2  = 3'd3;
    localparam logic [2:0] F_EMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [HGT_W-1:0]  prev_reg, prev_next;
    logic [3:0]        pend_reg, pend_next;

    logic [HGT_W-1:0]  h_reg;
    logic [ROW_W-1:0]  r_reg;
    logic [COL_W-1:0]  c_reg;
    logic [HGT_W-1:0]  car1_reg, car2_reg;
    logic [HGT_W-1:0]  up_rd_reg, mid_rd_reg;
    logic [DIFF_W-1:0] dx_reg, dz_reg;
    logic              int_reg;

    logic [HGT_W-1:0]  upper_mem  [MAX_COLS];
    logic [HGT_W-1:0]  middle_mem [MAX_COLS];

    logic [ROW_W-1:0]   rows_eff;
    logic [GCOLS_W-1:0] cols_eff;
    logic [GCOLS_W-1:0] c_ext;
    logic [COL_W-1:0]   c_m1;
    logic               last_col, last_row, interior;
    logic               mem_we;
    logic [COL_W-1:0]   wr_addr;
    logic [HGT_W-1:0]   up_wd, mid_wd;
    logic [3:0]         pick, rest;
    logic               accept;

    assign rows_eff = (grid_rows < 16'd3) ? 16'd3 : grid_rows;
    always_comb begin
        if (grid_cols < 8'd3) begin
            cols_eff = 8'd3;
        end else if (grid_cols > GCOLS_W'(MAX_COLS)) begin
            cols_eff = GCOLS_W'(MAX_COLS);
        end else begin
            cols_eff = grid_cols;
        end
    end

    assign c_ext    = GCOLS_W'(c_reg);
    assign c_m1     = c_reg - COL_W'(1);
    assign last_col = c_ext >= (cols_eff - 8'd1);
    assign last_row = r_reg >= (rows_eff - 16'd1);
    assign interior = (r_reg >= 16'd2) && (r_reg < rows_eff) &&
                      (c_ext >= 8'd2) && (c_ext < cols_eff);

    assign s_ready = (state_reg == F_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = c_m1;
        up_wd   = car1_reg;
        mid_wd  = prev_reg;
        if (state_reg == F_CALC) begin
            mem_we = (c_reg != '0);
        end else if (state_reg == F_WR2) begin
            mem_we  = 1'b1;
            wr_addr = c_reg;
            up_wd   = mid_rd_reg;
            mid_wd  = h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_READ) begin
            up_rd_reg  <= upper_mem[c_m1];
            mid_rd_reg <= middle_mem[c_reg];
        end
        if (mem_we) begin
            upper_mem[wr_addr]  <= up_wd;
            middle_mem[wr_addr] <= mid_wd;
        end
    end

    // lowest pending result goes first
    assign pick = pend_reg & (~pend_reg + 4'd1);
    assign rest = pend_reg & ~pick;

    always_comb begin
        q_data          = '0;
        q_data.dx       = dx_reg;
        q_data.dz       = dz_reg;
        q_data.last     = (rest == 4'd0);
        if (pick[0]) begin
            q_data.row      = r_reg - 16'd1;
            q_data.col      = c_m1;
            q_data.interior = int_reg;
        end else if (pick[1]) begin
            q_data.row = r_reg - 16'd1;
            q_data.col = c_reg;
        end else if (pick[2]) begin
            q_data.row = r_reg;
            q_data.col = c_m1;
        end else begin
            q_data.row      = r_reg;
            q_data.col      = c_reg;
            q_data.end_grid = 1'b1;
        end
    end

    assign q_push = (state_reg == F_EMIT) && !q_full;

    always_comb begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        prev_next    = prev_reg;
        pend_next    = pend_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_READ;
                end
            end
            F_READ: begin
                state_next = F_CALC;
            end
            F_CALC: begin
                pend_next = {last_row && last_col, last_row && (c_reg != '0),
                             last_col && (r_reg != '0), (c_reg != '0) && (r_reg != '0)};
                prev_next = h_reg;
                if (last_col) begin
                    col_cnt_next = '0;
                    row_cnt_next = last_row ? '0 : r_reg + 16'd1;
                    state_next   = F_WR2;
                end else begin
                    col_cnt_next = c_reg + COL_W'(1);
                    state_next   = (pend_next != 4'd0) ? F_EMIT : F_IDLE;
                end
            end
            F_WR2: begin
                state_next = (pend_reg != 4'd0) ? F_EMIT : F_IDLE;
            end
            F_EMIT: begin
                if (q_push) begin
                    pend_next = rest;
                    if (rest == 4'd0) begin
                        state_next = F_IDLE;
                    end
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            prev_reg    <= '0;
            pend_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            prev_reg    <= prev_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            h_reg <= s_height;
            r_reg <= row_cnt_reg;
            c_reg <= col_cnt_reg;
        end
        if (state_reg == F_CALC) begin
            dx_reg   <= DIFF_W'($signed(prev_reg)) - DIFF_W'($signed(up_rd_reg));
            dz_reg   <= DIFF_W'($signed(mid_rd_reg)) - DIFF_W'($signed(car2_reg));
            int_reg  <= interior;
            car1_reg <= mid_rd_reg;
            car2_reg <= car1_reg;
        end
    end

endmodule

### hdl/hsc_queue.sv
// Small job queue between the front end and the slope unit.
// Depends on hsc_pkg.
module hsc_queue import hsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  slope_job_t din,
    output logic       full,
    input  logic       pop,
    output slope_job_t dout,
    output logic       empty
);

    slope_job_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

### hdl/hsc_back.sv
// Slope unit: squares the differences, takes the square root one bit a cycle, classifies.
// Depends on hsc_pkg.
module hsc_back import hsc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  slope_job_t         q_data,
    output logic               q_pop,
    input  logic [THR_W-1:0]   steep_threshold,
    input  logic [THR_W-1:0]   moderate_threshold,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ROW_W-1:0]   m_cell_row,
    output logic [COL_W-1:0]   m_cell_col,
    output logic [MAG_W-1:0]   m_slope_mag,
    output logic [CLS_W-1:0]   m_steepness,
    output logic               m_last_of_run,
    output logic               m_end_of_grid
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_SQX  = 3'd1;
    localparam logic [2:0] B_SQZ  = 3'd2;
    localparam logic [2:0] B_ROOT = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    localparam int SUM_W  = 34;
    localparam int ROOT_W = 17;
    localparam int REM_W  = 20;

    logic [2:0]        state_reg, state_next;
    slope_job_t        job_reg;
    logic [31:0]       sq_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        iter_reg;
    logic [MAG_W-1:0]  mag_reg;

    logic [DIFF_W-1:0] ax_full, az_full;
    logic [15:0]       ax, az;
    logic [31:0]       az_sq;
    logic [REM_W-1:0]  rem_sh, trial;
    logic              ge;
    logic [ROOT_W-1:0] root_nx;

    assign ax_full = job_reg.dx[DIFF_W-1] ? (~job_reg.dx + DIFF_W'(1)) : job_reg.dx;
    assign az_full = job_reg.dz[DIFF_W-1] ? (~job_reg.dz + DIFF_W'(1)) : job_reg.dz;
    assign ax      = ax_full[15:0];
    assign az      = az_full[15:0];
    assign az_sq   = az * az;

    assign rem_sh  = {rem_reg[REM_W-3:0], acc_reg[SUM_W-1:SUM_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign ge      = rem_sh >= trial;
    assign root_nx = {root_reg[ROOT_W-2:0], ge};

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    state_next = q_data.interior ? B_SQX : B_OUT;
                end
            end
            B_SQX:  state_next = B_SQZ;
            B_SQZ:  state_next = B_ROOT;
            B_ROOT: begin
                if (iter_reg == 5'(ROOT_W - 1)) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (m_ready) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                job_reg <= q_data;
                mag_reg <= '0;
            end
            B_SQX: begin
                sq_reg <= ax * ax;
            end
            B_SQZ: begin
                acc_reg  <= SUM_W'(sq_reg) + SUM_W'(az_sq);
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= '0;
            end
            B_ROOT: begin
                acc_reg  <= {acc_reg[SUM_W-3:0], 2'b00};
                rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg <= root_nx;
                iter_reg <= iter_reg + 5'd1;
                if (iter_reg == 5'(ROOT_W - 1)) begin
                    mag_reg <= root_nx[ROOT_W-1:1];
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid       = (state_reg == B_OUT);
    assign m_cell_row    = job_reg.row;
    assign m_cell_col    = job_reg.col;
    assign m_slope_mag   = mag_reg;
    assign m_last_of_run = job_reg.last;
    assign m_end_of_grid = job_reg.end_grid;
    assign m_steepness   = (mag_reg > steep_threshold)    ? CLS_STEEP :
                           (mag_reg > moderate_threshold) ? CLS_MODERATE : CLS_FLAT;

endmodule

### hdl/heightmap_slope_classifier.sv
// Heightmap slope classifier top level: configuration registers, front end, queue, slope unit.
// Depends on hsc_pkg, hsc_front, hsc_queue, hsc_back.
//
//   port group   direction  handshake          payload
//   s_           in         s_valid/s_ready    s_height
//   m_           out        m_valid/m_ready    cell_row, cell_col, slope_mag, steepness,
//                                              last_of_run, end_of_grid
//   cfg_         in         cfg_we             cfg_index, cfg_data
//
// Front end, per height word: accept, line-buffer read, update, an extra line-buffer
// write on the last column, then one result job per cycle while the queue is not full.
// Slope unit, per interior result: pop, squares, 17 root steps, output; a border result
// goes from pop to output; a 4-entry queue lets the two sides stall on their own.
// Synchronous active-low reset clears control state; line buffers are not cleared.
module heightmap_slope_classifier import hsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [HGT_W-1:0]      s_height,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ROW_W-1:0]      m_cell_row,
    output logic [COL_W-1:0]      m_cell_col,
    output logic [MAG_W-1:0]      m_slope_mag,
    output logic [CLS_W-1:0]      m_steepness,
    output logic                  m_last_of_run,
    output logic                  m_end_of_grid,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ROW_W-1:0]   grid_rows_reg;
    logic [GCOLS_W-1:0] grid_cols_reg;
    logic [THR_W-1:0]   steep_thr_reg;
    logic [THR_W-1:0]   moderate_thr_reg;

    logic       q_push, q_full, q_pop, q_empty;
    slope_job_t q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg    <= RST_GRID_ROWS;
            grid_cols_reg    <= RST_GRID_COLS;
            steep_thr_reg    <= RST_STEEP_THR;
            moderate_thr_reg <= RST_MODERATE_THR;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data;
                REG_GRID_COLS:    grid_cols_reg    <= cfg_data[GCOLS_W-1:0];
                REG_STEEP_THR:    steep_thr_reg    <= cfg_data;
                REG_MODERATE_THR: moderate_thr_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    hsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_height  (s_height),
        .grid_rows (grid_rows_reg),
        .grid_cols (grid_cols_reg),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    hsc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .empty   (q_empty)
    );

    hsc_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_empty            (q_empty),
        .q_data             (q_out),
        .q_pop              (q_pop),
        .steep_threshold    (steep_thr_reg),
        .moderate_threshold (moderate_thr_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_cell_row         (m_cell_row),
        .m_cell_col         (m_cell_col),
        .m_slope_mag        (m_slope_mag),
        .m_steepness        (m_steepness),
        .m_last_of_run      (m_last_of_run),
        .m_end_of_grid      (m_end_of_grid)
    );

endmodule

### hdl/hsc_checker.sv
// Port-level checks of the heightmap slope classifier, bound to the top level.
// Depends on hsc_pkg and heightmap_slope_classifier.
module hsc_checker import hsc_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [HGT_W-1:0]      s_height,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ROW_W-1:0]      m_cell_row,
    input logic [COL_W-1:0]      m_cell_col,
    input logic [MAG_W-1:0]      m_slope_mag,
    input logic [CLS_W-1:0]      m_steepness,
    input logic                  m_last_of_run,
    input logic                  m_end_of_grid,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_row) && $stable(m_slope_mag))
        else $error("stalled output word changed");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_grid |-> m_last_of_run)
        else $error("grid end word not last of its run");

    a_zero_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_slope_mag == '0) |-> (m_steepness == CLS_FLAT))
        else $error("zero slope not classed flat");

    a_class_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_steepness != 2'd3))
        else $error("unused steepness code");

endmodule

bind heightmap_slope_classifier hsc_checker u_hsc_checker (.*);
